// ===== src/mbt_pkg.sv =====
`timescale 1ns / 1ps

package mbt_pkg;

    // Operation codes carried in the cmd field of a request
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic       full_error;
        logic [4:0] count;
    } out_item_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic        ins;
        logic        rem;
        logic        start;
        logic        scan;
        logic [31:0] key;
    } cell_ctrl_t;

    // Per-cell search status seen by the sequencer
    typedef struct packed {
        logic hit;
        logic miss;
    } cell_stat_t;

endpackage

// ===== src/multiset_bag_table_core.sv =====
`timescale 1ns / 1ps
// Sequencing: an insert or unused code goes from accept to ST_EMIT, then into the
// output register; a remove or query walks the search token through ST_SCAN up to
// the first match, the first empty cell or the end of a full chain, then ST_EMIT;
// output stalls hold ST_EMIT. Throughput: one request at a time, the token walking
// the cell chain one cell per cycle.
// Reset: rst_n clears occupancy, sequencer and tokens; entry data is not cleared.
module multiset_bag_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mbt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mbt_pkg::out_item_t  out_data
);
    import mbt_pkg::*;

    localparam int               OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] CAP_W = OCC_W'(CAPACITY);
    localparam logic [OCC_W-1:0] ONE_W = OCC_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      key_reg, key_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             found_reg, found_next;
    logic             full_reg, full_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    cell_ctrl_t       ctrl;
    cell_stat_t       stat [CAPACITY];
    logic [31:0]      cell_data [CAPACITY];
    logic [CAPACITY:0] tok_chain;
    logic [CAPACITY-1:0] tok_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] miss_vec;

    logic accept;
    logic has_room;
    logic hit_any;
    logic miss_any;
    logic scan_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign has_room  = (occ_reg < CAP_W);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Search ends on a hit, on reaching the first empty cell, or when the
    // token falls off the end of a full chain.
    assign hit_any   = |hit_vec;
    assign miss_any  = (|miss_vec) | tok_chain[CAPACITY];
    assign scan_done = (state_reg == ST_SCAN) & (hit_any | miss_any);

    always_comb
    begin
        ctrl.ins   = accept && (in_data.cmd == CMD_INSERT) && has_room;
        ctrl.start = accept && ((in_data.cmd == CMD_REMOVE) || (in_data.cmd == CMD_QUERY));
        ctrl.scan  = (state_reg == ST_SCAN);
        ctrl.rem   = (state_reg == ST_SCAN) && hit_any && (cmd_reg == CMD_REMOVE);
        ctrl.key   = key_reg;
    end

    // Chain of cells: cell 0 takes the inserted value, the token enters at cell 0
    assign tok_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = $unsigned(in_data.value);
        end
        else
        begin : g_body
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid
            assign right_w = cell_data[i+1];
        end

        mbt_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .occ        (occ_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .tok_in     (tok_chain[i]),
            .data       (cell_data[i]),
            .tok        (tok_vec[i]),
            .tok_out    (tok_chain[i+1]),
            .stat       (stat[i])
        );

        assign hit_vec[i]  = stat[i].hit;
        assign miss_vec[i] = stat[i].miss;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        occ_next       = occ_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_next       = out_reg;

        // Adjust the count alongside the cell shift
        if (ctrl.ins)
        begin
            occ_next = occ_reg + ONE_W;
        end
        else if (ctrl.rem)
        begin
            occ_next = occ_reg - ONE_W;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_data.cmd;
                    key_next   = $unsigned(in_data.value);
                    found_next = 1'b0;
                    full_next  = (in_data.cmd == CMD_INSERT) && !has_room;
                    state_next = ctrl.start ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    found_next = hit_any;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.found      = found_reg;
                    out_next.full_error = full_reg;
                    out_next.count      = 5'(occ_reg);
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        out_reg   <= out_next;
    end

    // Occupancy never exceeds the number of cells
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_W)
        else $error("occupancy above capacity");

    // At most one cell holds the search token
    a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the chain");

    // A remove shrinks the count by exactly one
    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rem |=> (occ_reg == $past(occ_reg) - ONE_W))
        else $error("remove did not drop occupancy by one");

    // A rejected insert reports a full store and no match
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.full_error) |->
            (!out_reg.found && (out_reg.count == 5'(CAP_W))))
        else $error("full_error with inconsistent result");

endmodule

// ===== src/mbt_cell.sv =====
`timescale 1ns / 1ps

module mbt_cell #(
    parameter int IDX   = 0,
    parameter int OCC_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbt_pkg::cell_ctrl_t ctrl,
    input  logic [OCC_W-1:0]   occ,
    input  logic [31:0]        left_data,
    input  logic [31:0]        right_data,
    input  logic               tok_in,
    output logic [31:0]        data,
    output logic               tok,
    output logic               tok_out,
    output mbt_pkg::cell_stat_t stat
);
    import mbt_pkg::*;

    localparam logic [OCC_W-1:0] IDX_W = OCC_W'(IDX);
    localparam logic             FIRST = (IDX == 0);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        tok_reg;
    logic        tok_next;
    logic        passed_reg;
    logic        passed_next;
    logic        occupied;
    logic        eq;

    assign occupied = (IDX_W < occ);
    assign eq       = (data_reg == ctrl.key);

    // Pass the token on when this entry is held and does not match
    assign tok_out   = tok_reg & occupied & ~eq;
    assign stat.hit  = tok_reg & occupied & eq;
    assign stat.miss = tok_reg & ~occupied;
    assign data      = data_reg;
    assign tok       = tok_reg;

    always_comb
    begin
        tok_next    = tok_reg;
        passed_next = passed_reg;
        data_next   = data_reg;
        if (ctrl.start)
        begin
            tok_next    = FIRST;
            passed_next = 1'b0;
        end
        else if (ctrl.scan)
        begin
            tok_next = tok_in;
            if (tok_out)
            begin
                passed_next = 1'b1;
            end
        end
        // Insert pushes everything up one cell; remove closes the hole
        // by pulling every cell at or beyond the match down by one.
        if (ctrl.ins)
        begin
            data_next = left_data;
        end
        else if (ctrl.rem && !passed_reg)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            passed_reg <= passed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== tb/tb_multiset_bag_table_core.sv =====
`timescale 1ns / 1ps

module tb_multiset_bag_table_core;

    import mbt_pkg::*;

    localparam int CAPACITY = 16;

    // Spare opcode: the block must answer with no match or full error and keep its contents
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Receiver hold-off that backs the block up, and the no-progress limit.
    // The limit sits well above that hold and any random stall, so it only trips
    // when the block has really stopped moving.
    localparam int BACKPRESSURE_HOLD = 400;
    localparam int WATCHDOG_LIMIT    = 4000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    multiset_bag_table_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Requests waiting to be offered, and bag answers still owed by the block
    in_item_t  pending_reqs[$];
    out_item_t owed_answers[$];

    // Shadow copy of the bag: held values and how many of them are live
    logic [31:0] bag_vals[CAPACITY];
    int          bag_fill;

    // Values the random sequences draw from, so that removes and queries find matches
    logic [31:0] value_pool[8];

    // Idle rates in percent, changed per phase from the control process at the falling edge
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    logic        backpressure_go;
    logic        backpressure_done;
    int          hold_left;

    int n_mismatch;
    int n_results;
    int n_queued;
    int n_inserts;
    int n_full_rejects;
    int n_removes;
    int n_remove_hits;
    int n_queries;
    int n_query_hits;
    int n_unused;
    int peak_fill;
    int stuck_cycles;

    always #1 clk = ~clk;

    // Apply one request to the shadow bag and return the answer the block must give.
    // Insert appends, remove takes the first match and moves the last entry into the hole.
    function automatic out_item_t apply_to_bag(in_item_t req);
        out_item_t ans;
        int        hit_idx;
        ans     = '0;
        hit_idx = -1;
        case (req.cmd)
            CMD_INSERT: begin
                n_inserts++;
                if (bag_fill >= CAPACITY) begin
                    ans.full_error = 1'b1;
                    n_full_rejects++;
                end
                else begin
                    bag_vals[bag_fill] = req.value;
                    bag_fill++;
                end
            end
            CMD_REMOVE, CMD_QUERY: begin
                // Compare raw bit patterns; only live entries take part
                for (int i = 0; i < bag_fill; i++)
                begin
                    if (hit_idx < 0 && bag_vals[i] == req.value)
                        hit_idx = i;
                end
                if (hit_idx >= 0)
                    ans.found = 1'b1;
                if (req.cmd == CMD_REMOVE) begin
                    n_removes++;
                    if (hit_idx >= 0) begin
                        n_remove_hits++;
                        bag_fill--;
                        bag_vals[hit_idx] = bag_vals[bag_fill];
                    end
                end
                else begin
                    n_queries++;
                    if (hit_idx >= 0)
                        n_query_hits++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        if (bag_fill > peak_fill)
            peak_fill = bag_fill;
        ans.count = 5'(bag_fill);
        return ans;
    endfunction

    function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("MISMATCH %0s: expected found=%0b full_error=%0b count=%0d, got found=%0b full_error=%0b count=%0d",
                     what, want.found, want.full_error, want.count,
                     got.found, got.full_error, got.count);
    endfunction

    // Driver: predict each request at the edge that accepts it, then offer the next one.
    // Payload and valid only change when nothing is offered or the offer was just taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else begin
            if (in_valid && in_ready)
                owed_answers.push_back(apply_to_bag(in_data));
            if (!in_valid || in_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted answer against the oldest owed one, and drive out_ready.
    // A requested backpressure window holds ready low for a fixed count of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            out_ready         <= 1'b0;
            hold_left         <= 0;
            backpressure_done <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (owed_answers.size() == 0) begin
                    note_mismatch("answer with none owed", '0, out_data);
                end
                else begin
                    want = owed_answers.pop_front();
                    if (out_data.found !== want.found)
                        note_mismatch("found", want, out_data);
                    if (out_data.full_error !== want.full_error)
                        note_mismatch("full_error", want, out_data);
                    if (out_data.count !== want.count)
                        note_mismatch("count", want, out_data);
                end
            end
            if (backpressure_go && !backpressure_done) begin
                hold_left         <= BACKPRESSURE_HOLD;
                backpressure_done <= 1'b1;
                out_ready         <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stuck_cycles <= 0;
            end
            else begin
                stuck_cycles <= stuck_cycles + 1;
                if (stuck_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog: no handshake for %0d cycles, %0d answers still owed",
                             WATCHDOG_LIMIT, owed_answers.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic queue_req(logic [1:0] op, logic [31:0] val);
        in_item_t req;
        req.cmd   = op;
        req.value = val;
        pending_reqs.push_back(req);
        n_queued++;
    endtask

    // Keep extremes in the pool and refresh the rest with fresh random words
    task automatic refresh_pool();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
        begin
            value_pool[i] = $urandom;
        end
    endtask

    // Mostly pool values so hits happen; now and then a fully random word
    function automatic logic [31:0] pick_value();
        if ($urandom_range(9) < 8)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Random traffic in short sequences: mixed operations, fill bursts that run
    // into the capacity limit, and drain bursts of removes that shrink the bag again.
    task automatic queue_random(int how_many);
        int          stop_at;
        int unsigned kind;
        int unsigned r;
        logic [1:0]  op;
        stop_at = n_queued + how_many;
        refresh_pool();
        while (n_queued < stop_at)
        begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                repeat (8)
                begin
                    r = $urandom_range(99);
                    if (r < 40)
                        op = CMD_INSERT;
                    else if (r < 70)
                        op = CMD_REMOVE;
                    else if (r < 95)
                        op = CMD_QUERY;
                    else
                        op = CMD_UNUSED;
                    queue_req(op, pick_value());
                end
            end
            else if (kind < 8) begin
                repeat (CAPACITY + 2)
                    queue_req(CMD_INSERT, pick_value());
            end
            else begin
                repeat (CAPACITY + 2)
                    queue_req(CMD_REMOVE, pick_value());
            end
        end
    endtask

    // Wait at falling edges until nothing is queued, offered or owed
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || owed_answers.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        sender_idle_pct   = 0;
        recv_stall_pct    = 0;
        backpressure_go   = 1'b0;
        bag_fill          = 0;
        n_mismatch        = 0;
        n_results         = 0;
        n_queued          = 0;
        n_inserts         = 0;
        n_full_rejects    = 0;
        n_removes         = 0;
        n_remove_hits     = 0;
        n_queries         = 0;
        n_query_hits      = 0;
        n_unused          = 0;
        peak_fill         = 0;
        stuck_cycles      = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-bag lookups, extreme values, first-match removal with the
        // last entry moved into the hole, a miss, the spare opcode, then fill to
        // capacity and push one insert past it.
        queue_req(CMD_QUERY,  32'h0000_0000);
        queue_req(CMD_REMOVE, 32'hFFFF_FFFF);
        queue_req(CMD_INSERT, 32'h8000_0000);
        queue_req(CMD_INSERT, 32'h7FFF_FFFF);
        queue_req(CMD_INSERT, 32'h0000_0000);
        queue_req(CMD_INSERT, 32'hFFFF_FFFF);
        queue_req(CMD_INSERT, 32'h7FFF_FFFF);
        queue_req(CMD_QUERY,  32'h7FFF_FFFF);
        queue_req(CMD_REMOVE, 32'h8000_0000);
        queue_req(CMD_QUERY,  32'hFFFF_FFFF);
        queue_req(CMD_REMOVE, 32'h7FFF_FFFF);
        queue_req(CMD_REMOVE, 32'h0000_3039);
        queue_req(CMD_UNUSED, 32'hFFFF_FFFF);
        repeat (CAPACITY - 3)
            queue_req(CMD_INSERT, 32'h5555_AAAA);
        queue_req(CMD_INSERT, 32'hAAAA_5555);
        queue_req(CMD_QUERY,  32'h5555_AAAA);

        // Phase with no idling on either side
        queue_random(100);
        wait_drained();

        sender_idle_pct = 57;
        recv_stall_pct  = 0;
        queue_random(125);
        wait_drained();

        sender_idle_pct = 0;
        recv_stall_pct  = 57;
        queue_random(125);
        wait_drained();

        sender_idle_pct = 34;
        recv_stall_pct  = 34;
        queue_random(125);
        wait_drained();

        // Backpressure: hold the receiver off while the sender keeps offering
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        queue_random(40);
        backpressure_go = 1'b1;
        wait_drained();

        // Let the block settle for its longest request time, then check for leftovers
        repeat (CAPACITY + 4) @(negedge clk);
        if (owed_answers.size() != 0) begin
            n_mismatch += owed_answers.size();
            $display("%0d answers never arrived", owed_answers.size());
        end

        $display("Ran %0d requests, %0d answers: %0d inserts (%0d rejected full), %0d removes (%0d hits)",
                 n_queued, n_results, n_inserts, n_full_rejects, n_removes, n_remove_hits);
        $display("%0d queries (%0d hits), %0d spare opcodes, peak fill %0d of %0d, %0d mismatches",
                 n_queries, n_query_hits, n_unused, peak_fill, CAPACITY, n_mismatch);
        if (n_mismatch == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
